// ----- src/i2cm_pkg.sv -----
package i2cm_pkg;

    localparam int MODE_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int SBITS_W  = 9;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 7;

    localparam logic [MODE_W-1:0] MODE_WR_ADDR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RD_ADDR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WR_BYTE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RD_ACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RD_NACK = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STOP    = 3'd5;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_ADDR_NACK = 2'd1;
    localparam logic [STATUS_W-1:0] STS_DATA_NACK = 2'd2;
    localparam logic [STATUS_W-1:0] STS_SKIPPED   = 2'd3;

    typedef enum logic [1:0] {
        SDA_ONE,
        SDA_ZERO,
        SDA_DATA
    } t_sda_sel;

    typedef struct packed {
        logic                load;
        logic                load_addr;
        logic                start_cmd;
        logic                set_abort;
        logic                shift;
        logic                emit;
        logic                scl;
        t_sda_sel            sda_sel;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic                rx_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic aborted;
        logic read_dir;
        logic nack;
    } t_dp_sts;

endpackage

// ----- src/i2c_master_byte_engine.sv -----
// Byte-level I2C master, 7-bit addressing. Each request on s_axis is one bus command
// (start+address write/read, write byte, read byte with ack, read last byte with nack
// and stop, stop); the block answers with a run of SCL/SDA line phases on m_axis, one
// beat per phase, tlast on the final one, which also carries the status in tuser and the
// received byte. The slave's sampled SDA for the nine SCL-high phases comes with the
// request. A nack, or a final read with nack, adds a stop to the run. The phase
// sequencer emits one phase per cycle while m_axis keeps up, and takes the next
// request only once the current run is fully generated. Undefined modes are dropped.
module i2c_master_byte_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // tx_byte[7:0], slave_bits[16:8], zero pad
    input  logic [2:0]  s_axis_tuser,   // mode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // scl_level[0], sda_level[1], rx_byte[9:2], zero pad
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cm_pkg::*;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic              cfg_we;
    logic [ADDR_W-1:0] dev_addr;
    logic              scl;
    logic              sda;
    logic [BYTE_W-1:0] rx_byte;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {25'd0, dev_addr};

    i2cm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_mode      (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    i2cm_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (pwdata[ADDR_W-1:0]),
        .o_dev_addr   (dev_addr),
        .i_mode       (s_axis_tuser),
        .i_tx_byte    (s_axis_tdata[7:0]),
        .i_slave_bits (s_axis_tdata[16:8]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_scl        (scl),
        .o_sda        (sda),
        .o_last       (m_axis_tlast),
        .o_status     (m_axis_tuser),
        .o_rx_byte    (rx_byte)
    );

    assign m_axis_tdata = {6'd0, rx_byte, sda, scl};

    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == STS_OK && rx_byte == '0)
        else $error("status or rx byte set on a phase that is not last");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser <= MODE_STOP |=> !s_axis_tready)
        else $error("second request taken while a command is running");

    a_skip_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STS_SKIPPED |-> m_axis_tlast && scl && sda)
        else $error("skipped command phase malformed");

    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tuser != STS_OK |-> scl && sda)
        else $error("nack run does not end with a stop");

endmodule

// ----- src/i2cm_ctrl.sv -----
module i2cm_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [2:0]               i_mode,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    input  i2cm_pkg::t_dp_sts        i_sts,
    output i2cm_pkg::t_dp_cmd        o_cmd
);
    import i2cm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_BITS,
        ST_ACK,
        ST_STOP,
        ST_SKIP
    } t_state;

    t_state              r_state, n_state;
    logic [3:0]          r_cnt, n_cnt;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_valid, n_valid;

    logic emit_ok;
    logic is_read;

    assign emit_ok = !r_valid || i_out_ready;
    assign is_read = (r_mode == MODE_RD_ACK) || (r_mode == MODE_RD_NACK);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_mode     = r_mode;
        n_status   = r_status;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.sda_sel = SDA_ONE;
        o_cmd.status  = STS_OK;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_mode     = i_mode;
                    n_cnt      = '0;
                    unique case (i_mode)
                        MODE_WR_ADDR, MODE_RD_ADDR: begin
                            o_cmd.load_addr = 1'b1;
                            o_cmd.start_cmd = 1'b1;
                            n_state = ST_START;
                        end
                        MODE_WR_BYTE: begin
                            n_state = (i_sts.aborted || i_sts.read_dir) ? ST_SKIP : ST_BITS;
                        end
                        MODE_RD_ACK, MODE_RD_NACK: begin
                            n_state = (i_sts.aborted || !i_sts.read_dir) ? ST_SKIP : ST_BITS;
                        end
                        MODE_STOP: begin
                            n_status = STS_OK;
                            n_state  = ST_STOP;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_START: begin
                if (emit_ok) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.scl     = (r_cnt == 4'd1) || (r_cnt == 4'd2);
                    o_cmd.sda_sel = (r_cnt < 4'd2) ? SDA_ONE : SDA_ZERO;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd3) begin
                        n_cnt   = '0;
                        n_state = ST_BITS;
                    end
                end
            end
            ST_BITS: begin
                if (emit_ok) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.scl     = r_cnt[0];
                    o_cmd.sda_sel = is_read ? SDA_ONE : SDA_DATA;
                    o_cmd.shift   = r_cnt[0];
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        n_cnt   = '0;
                        n_state = ST_ACK;
                    end
                end
            end
            ST_ACK: begin
                if (emit_ok) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.scl     = (r_cnt == 4'd1);
                    o_cmd.sda_sel = (r_mode == MODE_RD_ACK) ? SDA_ZERO : SDA_ONE;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd2) begin
                        n_cnt = '0;
                        if (!is_read && i_sts.nack) begin
                            o_cmd.set_abort = 1'b1;
                            n_status = (r_mode == MODE_WR_BYTE) ? STS_DATA_NACK : STS_ADDR_NACK;
                            n_state  = ST_STOP;
                        end else if (r_mode == MODE_RD_NACK) begin
                            n_status = STS_OK;
                            n_state  = ST_STOP;
                        end else begin
                            o_cmd.last   = 1'b1;
                            o_cmd.rx_sel = is_read;
                            n_state      = ST_IDLE;
                        end
                    end
                end
            end
            ST_STOP: begin
                if (emit_ok) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.scl     = (r_cnt != 4'd0);
                    o_cmd.sda_sel = (r_cnt == 4'd2) ? SDA_ONE : SDA_ZERO;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd2) begin
                        o_cmd.last   = 1'b1;
                        o_cmd.status = r_status;
                        o_cmd.rx_sel = (r_mode == MODE_RD_NACK);
                        n_cnt        = '0;
                        n_state      = ST_IDLE;
                    end
                end
            end
            ST_SKIP: begin
                if (emit_ok) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.scl    = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = STS_SKIPPED;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_mode   <= MODE_WR_ADDR;
            r_status <= STS_OK;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_mode   <= n_mode;
            r_status <= n_status;
            r_valid  <= n_valid;
        end
    end

    assign o_out_valid = r_valid;

endmodule

// ----- src/i2cm_datapath.sv -----
module i2cm_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [6:0]               i_cfg_addr,
    output logic [6:0]               o_dev_addr,
    input  logic [2:0]               i_mode,
    input  logic [7:0]               i_tx_byte,
    input  logic [8:0]               i_slave_bits,
    input  i2cm_pkg::t_dp_cmd        i_cmd,
    output i2cm_pkg::t_dp_sts        o_sts,
    output logic                     o_scl,
    output logic                     o_sda,
    output logic                     o_last,
    output logic [1:0]               o_status,
    output logic [7:0]               o_rx_byte
);
    import i2cm_pkg::*;

    logic [ADDR_W-1:0]   r_dev_addr;
    logic                r_aborted;
    logic                r_read_dir;
    logic [BYTE_W-1:0]   r_shift;
    logic [SBITS_W-1:0]  r_bits;
    logic                r_scl;
    logic                r_sda;
    logic                r_last;
    logic [STATUS_W-1:0] r_status;
    logic [BYTE_W-1:0]   r_rx;

    logic n_sda;

    always_comb begin
        unique case (i_cmd.sda_sel)
            SDA_ZERO: n_sda = 1'b0;
            SDA_DATA: n_sda = r_shift[BYTE_W-1];
            default:  n_sda = 1'b1;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= '0;
            r_aborted  <= 1'b0;
            r_read_dir <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dev_addr <= i_cfg_addr;
            end
            if (i_cmd.start_cmd) begin
                r_aborted  <= 1'b0;
                r_read_dir <= i_mode[0];
            end else if (i_cmd.set_abort) begin
                r_aborted <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bits  <= i_slave_bits;
            r_shift <= i_cmd.load_addr ? {r_dev_addr, i_mode[0]} : i_tx_byte;
        end else if (i_cmd.shift) begin
            r_shift <= {r_shift[BYTE_W-2:0], 1'b0};
        end
        if (i_cmd.emit) begin
            r_scl    <= i_cmd.scl;
            r_sda    <= n_sda;
            r_last   <= i_cmd.last;
            r_status <= i_cmd.status;
            r_rx     <= i_cmd.rx_sel ? r_bits[SBITS_W-1:1] : '0;
        end
    end

    assign o_sts.aborted  = r_aborted;
    assign o_sts.read_dir = r_read_dir;
    assign o_sts.nack     = r_bits[0];
    assign o_dev_addr     = r_dev_addr;
    assign o_scl          = r_scl;
    assign o_sda          = r_sda;
    assign o_last         = r_last;
    assign o_status       = r_status;
    assign o_rx_byte      = r_rx;

endmodule

// ----- tb/i2c_master_byte_engine_checker.sv -----
`timescale 1ns / 100ps

module i2c_master_byte_engine_checker #(
    parameter logic [2:0] DEV_ADDR_REG = '0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // tx_byte[7:0], slave_bits[16:8], zero pad
    input  logic [2:0]  i_s_axis_tuser,   // mode[2:0]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // scl_level[0], sda_level[1], rx_byte[9:2], zero pad
    input  logic        i_m_axis_tlast,
    input  logic [1:0]  i_m_axis_tuser,   // status[1:0]
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    import i2cm_pkg::*;

    typedef struct packed {
        logic                scl;
        logic                sda;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   rx;
    } t_line_phase;

    t_line_phase       line_phase_q[$];
    logic              aborted_st;
    logic              read_dir_st;
    logic [ADDR_W-1:0] dev_addr;

    function automatic void add_phase(input logic scl, input logic sda);
        t_line_phase p;
        p        = '0;
        p.scl    = scl;
        p.sda    = sda;
        line_phase_q.push_back(p);
    endfunction

    function automatic void close_run(input logic [STATUS_W-1:0] status,
                                      input logic [BYTE_W-1:0] rx);
        line_phase_q[$].last   = 1'b1;
        line_phase_q[$].status = status;
        line_phase_q[$].rx     = rx;
    endfunction

    function automatic void add_start();
        add_phase(1'b0, 1'b1);
        add_phase(1'b1, 1'b1);
        add_phase(1'b1, 1'b0);
        add_phase(1'b0, 1'b0);
    endfunction

    function automatic void add_stop();
        add_phase(1'b0, 1'b0);
        add_phase(1'b1, 1'b0);
        add_phase(1'b1, 1'b1);
    endfunction

    // eight data bits msb first, then the slave ack slot; returns the nack
    function automatic logic add_tx_byte(input logic [BYTE_W-1:0] value,
                                         input logic [SBITS_W-1:0] sampled);
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            add_phase(1'b0, value[i]);
            add_phase(1'b1, value[i]);
        end
        add_phase(1'b0, 1'b1);
        add_phase(1'b1, 1'b1);
        add_phase(1'b0, 1'b1);
        return sampled[0];
    endfunction

    function automatic void add_rx_byte(input logic master_nack);
        for (int i = 0; i < BYTE_W; i++) begin
            add_phase(1'b0, 1'b1);
            add_phase(1'b1, 1'b1);
        end
        add_phase(1'b0, master_nack);
        add_phase(1'b1, master_nack);
        add_phase(1'b0, master_nack);
    endfunction

    function automatic void predict_command(input logic [MODE_W-1:0] mode,
                                            input logic [BYTE_W-1:0] tx,
                                            input logic [SBITS_W-1:0] sampled);
        case (mode)
            MODE_WR_ADDR, MODE_RD_ADDR: begin
                aborted_st  = 1'b0;
                read_dir_st = (mode == MODE_RD_ADDR);
                add_start();
                if (add_tx_byte({dev_addr, read_dir_st}, sampled)) begin
                    add_stop();
                    aborted_st = 1'b1;
                    close_run(STS_ADDR_NACK, '0);
                end else begin
                    close_run(STS_OK, '0);
                end
            end
            MODE_WR_BYTE: begin
                if (aborted_st || read_dir_st) begin
                    add_phase(1'b1, 1'b1);
                    close_run(STS_SKIPPED, '0);
                end else if (add_tx_byte(tx, sampled)) begin
                    add_stop();
                    aborted_st = 1'b1;
                    close_run(STS_DATA_NACK, '0);
                end else begin
                    close_run(STS_OK, '0);
                end
            end
            MODE_RD_ACK, MODE_RD_NACK: begin
                if (aborted_st || !read_dir_st) begin
                    add_phase(1'b1, 1'b1);
                    close_run(STS_SKIPPED, '0);
                end else begin
                    add_rx_byte(mode == MODE_RD_NACK);
                    if (mode == MODE_RD_NACK) begin
                        add_stop();
                    end
                    close_run(STS_OK, sampled[8:1]);
                end
            end
            MODE_STOP: begin
                add_stop();
                close_run(STS_OK, '0);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_line_phase got;
        t_line_phase want;
        if (!i_rst_n) begin
            aborted_st   = 1'b0;
            read_dir_st  = 1'b0;
            dev_addr     = '0;
            o_fail_count = 0;
            line_phase_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == DEV_ADDR_REG) begin
                dev_addr = i_pwdata[ADDR_W-1:0];
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_command(i_s_axis_tuser, i_s_axis_tdata[7:0], i_s_axis_tdata[16:8]);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.scl    = i_m_axis_tdata[0];
                got.sda    = i_m_axis_tdata[1];
                got.rx     = i_m_axis_tdata[9:2];
                got.last   = i_m_axis_tlast;
                got.status = i_m_axis_tuser;
                if (line_phase_q.size() == 0) begin
                    $error("line phase with none expected: scl %0b sda %0b last %0b",
                           got.scl, got.sda, got.last);
                    o_fail_count++;
                end else begin
                    want = line_phase_q.pop_front();
                    check_field("scl_level", int'(want.scl), int'(got.scl));
                    check_field("sda_level", int'(want.sda), int'(got.sda));
                    check_field("last", int'(want.last), int'(got.last));
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("rx_byte", int'(want.rx), int'(got.rx));
                end
            end
        end
        o_pending = line_phase_q.size();
    end

endmodule

// ----- tb/i2c_master_byte_engine_tb.sv -----
`timescale 1ns / 100ps

module i2c_master_byte_engine_tb;
    import i2cm_pkg::*;

    localparam logic [2:0]        REG_DEV_ADDR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;
    localparam int CMD_TARGET  = 370;
    localparam int SETTLE      = 30;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 800000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // tx_byte[7:0], slave_bits[16:8], zero pad
    logic [2:0]  s_axis_tuser = '0;   // mode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // scl_level[0], sda_level[1], rx_byte[9:2], zero pad
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;        // status[1:0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int   fail_count;
    int   pending;
    int   cmd_count = 0;
    int   cycle_count = 0;
    logic idle_on = 1'b1;
    logic hold_off_req = 1'b0;
    logic hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    i2c_master_byte_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    i2c_master_byte_engine_checker #(
        .DEV_ADDR_REG (REG_DEV_ADDR)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[i2c_master_byte_engine] ERROR");
            $finish;
        end
    end

    function automatic logic nack_bit();
        return ($urandom_range(0, 9) == 0);
    endfunction

    task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] tx,
                            input logic [SBITS_W-1:0] sampled);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {7'b0, sampled, tx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (mode <= MODE_STOP) begin
            cmd_count++;
        end
    endtask

    // stop offering and wait until every line phase has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    task automatic write_dev_addr(input logic [ADDR_W-1:0] value);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_DEV_ADDR;
        pwdata  <= {25'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // start, one to four bytes mostly in the chosen direction, then a stop on writes and sometimes on reads
    task automatic run_transfer();
        logic rd;
        int   n;
        if ($urandom_range(0, 15) == 0) begin
            idle_on = !idle_on;
        end
        rd = 1'($urandom_range(0, 1));
        n  = $urandom_range(1, 4);
        send_cmd(rd ? MODE_RD_ADDR : MODE_WR_ADDR, 8'($urandom), {8'($urandom), nack_bit()});
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_cmd(rd ? MODE_WR_BYTE : MODE_RD_ACK, 8'($urandom), 9'($urandom));
            end else if (!rd) begin
                send_cmd(MODE_WR_BYTE, 8'($urandom), {8'($urandom), nack_bit()});
            end else begin
                send_cmd((i == n - 1) ? MODE_RD_NACK : MODE_RD_ACK, 8'($urandom),
                         9'($urandom));
            end
        end
        if (!rd || $urandom_range(0, 7) == 0) begin
            send_cmd(MODE_STOP, 8'($urandom), 9'($urandom));
        end
    endtask

    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            if (hold_off_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end
            stall = idle_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        int target;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_dev_addr('0);

        send_cmd(MODE_STOP, 8'h00, 9'h000);
        send_cmd(MODE_WR_BYTE, 8'h3C, 9'h000);
        send_cmd(MODE_RD_ACK, 8'h00, 9'h000);
        send_cmd(MODE_WR_ADDR, 8'hFF, 9'h1FE);
        send_cmd(MODE_WR_BYTE, 8'hFF, 9'h1FE);
        send_cmd(MODE_WR_BYTE, 8'h00, 9'h000);
        send_cmd(MODE_RD_NACK, 8'h00, 9'h000);
        send_cmd(MODE_WR_BYTE, 8'hA5, 9'h001);
        send_cmd(MODE_WR_BYTE, 8'h5A, 9'h000);
        send_cmd(MODE_RD_ACK, 8'h00, 9'h000);
        send_cmd(MODE_STOP, 8'h00, 9'h000);
        send_cmd(MODE_RD_ADDR, 8'h00, 9'h000);
        send_cmd(MODE_RD_ACK, 8'h00, 9'h1FF);
        send_cmd(MODE_RD_ACK, 8'hFF, 9'h000);
        send_cmd(MODE_WR_BYTE, 8'h81, 9'h000);
        send_cmd(MODE_RD_NACK, 8'h00, 9'h155);
        send_cmd(MODE_RD_ADDR, 8'h00, 9'h001);
        send_cmd(MODE_RD_ACK, 8'h00, 9'h000);
        send_cmd(MODE_WR_BYTE, 8'h18, 9'h000);
        send_cmd(MODE_UNDEF_LO, 8'hFF, 9'h1FF);
        send_cmd(MODE_UNDEF_HI, 8'h00, 9'h000);
        send_cmd(MODE_WR_ADDR, 8'h00, 9'h001);
        send_cmd(MODE_STOP, 8'h00, 9'h000);
        send_cmd(MODE_WR_ADDR, 8'h00, 9'h000);
        send_cmd(MODE_STOP, 8'h00, 9'h000);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: write_dev_addr(7'h7F);
                2: write_dev_addr('0);
                default: write_dev_addr(7'($urandom_range(0, 127)));
            endcase
            if (p == 1) begin
                // stall the result side while requests keep coming
                hold_off_req = 1'b1;
                run_transfer();
                run_transfer();
                drain();
            end
            target = CMD_TARGET * (p + 1) / 4;
            while (cmd_count < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_cmd(3'($urandom), 8'($urandom), 9'($urandom));
                end else begin
                    run_transfer();
                end
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[i2c_master_byte_engine] OK");
        end else begin
            $display("[i2c_master_byte_engine] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/i2cm_pkg.sv
src/i2cm_ctrl.sv
src/i2cm_datapath.sv
src/i2c_master_byte_engine.sv
tb/i2c_master_byte_engine_checker.sv
tb/i2c_master_byte_engine_tb.sv
